@@ src/mfbr_pkg.sv @@
package mfbr_pkg;

  localparam int unsigned BufferDepth = 32;
  localparam int unsigned IdxW        = $clog2(BufferDepth);
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgIdxW     = 4;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t RegStartMarker = cfg_idx_t'(0);
  localparam cfg_idx_t RegEndMarker   = cfg_idx_t'(1);

  localparam byte_t StartMarkerReset = byte_t'(60);  // '<'
  localparam byte_t EndMarkerReset   = byte_t'(62);  // '>'

  localparam idx_t LastSlot = idx_t'(BufferDepth - 1);

endpackage

@@ src/mfbr_ifs.sv @@
interface mfbr_rx_if;
  import mfbr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfbr_tx_if;
  import mfbr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  is_last;
  logic  frame_empty;

  modport source (output valid, output frame_byte, output is_last, output frame_empty,
                  input ready);
  modport sink   (input valid, input frame_byte, input is_last, input frame_empty,
                  output ready);
endinterface

interface mfbr_cfg_if;
  import mfbr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t reg_index;
  byte_t    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/mfbr_ram.sv @@
module mfbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/marker_framed_byte_receiver_core.sv @@
// Channel  | Dir | Payload                              | Request taken when
// ---------+-----+--------------------------------------+----------------------------
// rx_i     | in  | rx_byte[7:0]                         | rx_i.valid & rx_i.ready
// tx_o     | out | frame_byte[7:0], is_last, frame_empty | tx_o.valid & tx_o.ready
// cfg_i    | in  | reg_index[3:0], wdata[7:0]           | cfg_i.valid (always ready)
//
// An end marker starts a drain: for each stored payload byte, a RAM read
// (S_READ), then an output load (S_LOAD) held while tx_o stalls; an empty
// frame goes straight to S_LOAD. rx_i is not ready meanwhile.
// Reset (rst_ni, async, active low) closes the frame, clears the write index and
// restores the default markers. The payload RAM is not cleared.
module marker_framed_byte_receiver_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  mfbr_rx_if.sink    rx_i,
  mfbr_tx_if.source  tx_o,
  mfbr_cfg_if.sink   cfg_i
);
  import mfbr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q;
  byte_t  start_marker_q, end_marker_q;
  logic   in_frame_q;
  idx_t   widx_q;     // next payload slot
  idx_t   cnt_q;      // payload bytes of the draining frame
  idx_t   rd_idx_q;   // slot being drained
  logic   empty_q;    // draining frame had no payload

  logic   out_valid_q;
  byte_t  out_byte_q;
  logic   out_last_q;
  logic   out_empty_q;

  // shared compare unit: the marker of interest depends on frame state
  byte_t  cmp_marker;
  logic   marker_hit;
  // shared incrementer: write index while receiving, read index while draining
  idx_t   inc_src, inc_res;

  logic   rx_take, out_free, ram_we, ram_re;
  byte_t  ram_rdata;

  assign cmp_marker = in_frame_q ? end_marker_q : start_marker_q;
  assign marker_hit = (rx_i.rx_byte == cmp_marker);

  assign inc_src = (state_q == S_IDLE) ? widx_q : rd_idx_q;
  assign inc_res = inc_src + idx_t'(1);

  assign rx_i.ready = (state_q == S_IDLE);
  assign rx_take    = rx_i.valid && rx_i.ready;
  assign out_free   = !out_valid_q || tx_o.ready;

  // store every in-frame byte that is not the end marker
  assign ram_we = rx_take && in_frame_q && !marker_hit;
  assign ram_re = (state_q == S_READ);

  assign cfg_i.ready = 1'b1;

  mfbr_ram #(
    .Width (ByteW),
    .Depth (BufferDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (rx_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      start_marker_q <= StartMarkerReset;
      end_marker_q   <= EndMarkerReset;
      in_frame_q     <= 1'b0;
      widx_q         <= '0;
      cnt_q          <= '0;
      rd_idx_q       <= '0;
      empty_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      out_byte_q     <= '0;
      out_last_q     <= 1'b0;
      out_empty_q    <= 1'b0;
    end else begin
      // configuration writes; unknown indexes are dropped
      if (cfg_i.valid) begin
        if (cfg_i.reg_index == RegStartMarker) begin
          start_marker_q <= cfg_i.wdata;
        end else if (cfg_i.reg_index == RegEndMarker) begin
          end_marker_q <= cfg_i.wdata;
        end
      end

      // retire the output request once taken; S_LOAD reloads it on its own
      if (out_valid_q && tx_o.ready && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (rx_take) begin
            if (!in_frame_q) begin
              // drop everything but the start marker
              if (marker_hit) begin
                in_frame_q <= 1'b1;
              end
            end else if (!marker_hit) begin
              // advance, saturating on the last slot
              if (widx_q != LastSlot) begin
                widx_q <= inc_res;
              end
            end else begin
              // end marker: close the frame and start draining
              in_frame_q <= 1'b0;
              widx_q     <= '0;
              cnt_q      <= widx_q;
              rd_idx_q   <= '0;
              empty_q    <= (widx_q == '0);
              state_q    <= (widx_q == '0) ? S_LOAD : S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // hold until the output register frees up
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_empty_q <= empty_q;
            if (empty_q) begin
              out_byte_q <= '0;
              out_last_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              out_byte_q <= ram_rdata;
              out_last_q <= (inc_res == cnt_q);
              rd_idx_q   <= inc_res;
              state_q    <= (inc_res == cnt_q) ? S_IDLE : S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign tx_o.valid       = out_valid_q;
  assign tx_o.frame_byte  = out_byte_q;
  assign tx_o.is_last     = out_last_q;
  assign tx_o.frame_empty = out_empty_q;

`ifndef NO_ASSERTIONS
  // an empty frame is a single zero result that closes the frame
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_last_q && (out_byte_q == '0))
    else $error("empty frame result not last or not zero");

  // draining never reads past the stored payload
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && !empty_q |-> (rd_idx_q < cnt_q))
    else $error("drain index past payload count");

  // outside a frame the write index is at zero
  a_idx_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (widx_q == '0))
    else $error("write index not cleared outside frame");

  // a stalled output holds the drain sequencer
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) && out_valid_q && !tx_o.ready |=>
      (state_q == S_LOAD) && $stable(rd_idx_q))
    else $error("drain advanced under output stall");

  // a frame is not open while its predecessor drains
  a_no_frame_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_frame_q)
    else $error("frame open during drain");
`endif

endmodule

@@ bench/tb.sv @@
module tb;
  import mfbr_pkg::*;

  // One result as the block presents it on tx_o.
  typedef struct packed {
    byte_t frame_byte;
    logic  is_last;
    logic  frame_empty;
  } beat_t;

  // Register indexes past the two real ones; writes to them must change nothing.
  localparam cfg_idx_t RegSpareLo = cfg_idx_t'(2);
  localparam cfg_idx_t RegSpareHi = cfg_idx_t'(2 ** CfgIdxW - 1);

  logic clk_i;
  logic rst_ni;

  mfbr_rx_if  rx_if ();
  mfbr_tx_if  tx_if ();
  mfbr_cfg_if cfg_if ();

  marker_framed_byte_receiver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the receiver: markers, frame flag, fill index and payload slots.
  byte_t start_mark = StartMarkerReset;
  byte_t end_mark   = EndMarkerReset;
  bit    frame_open = 1'b0;
  idx_t  fill_idx   = '0;
  byte_t payload_mem [BufferDepth];

  beat_t pending_beats [$];   // results owed by the block, oldest first
  int    mismatch_cnt = 0;
  int    used_items   = 0;    // requests that opened, filled or closed a frame
  bit    quiet        = 1'b0; // hold both sides free of idle cycles

  // Clock: period 4.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Advance the mirror by one received byte. Queue the results it releases.
  // Return 0 when the byte is dropped outside a frame.
  function automatic bit frame_assemble(byte_t b);
    if (!frame_open) begin
      frame_open = (b == start_mark);
      return frame_open;
    end
    // Any byte but the end marker is payload, the start marker included.
    // The index sticks at the last slot, so overflow keeps rewriting that
    // slot and it never reaches the output.
    if (b != end_mark) begin
      payload_mem[fill_idx] = b;
      if (fill_idx != LastSlot) fill_idx++;
      return 1'b1;
    end
    frame_open = 1'b0;
    if (fill_idx == '0) begin
      // empty frame: a single flagged result with a zero byte
      pending_beats.push_back('{8'h00, 1'b1, 1'b1});
    end else begin
      for (int k = 0; k < int'(fill_idx); k++) begin
        pending_beats.push_back('{payload_mem[k], logic'(k == int'(fill_idx) - 1), 1'b0});
      end
    end
    fill_idx = '0;
    return 1'b1;
  endfunction

  function automatic void flag_mismatch(bit has_want, beat_t want, beat_t got);
    mismatch_cnt++;
    if (mismatch_cnt > 10) return;
    if (!has_want)
      $display("%0t unexpected result: byte %02h last %b empty %b",
               $time, got.frame_byte, got.is_last, got.frame_empty);
    else
      $display("%0t mismatch: expected byte %02h last %b empty %b, got byte %02h last %b empty %b",
               $time, want.frame_byte, want.is_last, want.frame_empty,
               got.frame_byte, got.is_last, got.frame_empty);
  endfunction

  // Send one byte request. Enter and leave at a falling edge; valid is left
  // high so that back-to-back requests never lower and raise it in one step.
  task automatic send_rx_byte(byte_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    if (frame_assemble(b)) used_items++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic drain_frames();
    rx_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, byte_t val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      RegStartMarker: start_mark = val;
      RegEndMarker:   end_mark   = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_markers(byte_t s, byte_t e);
    drain_frames();
    write_reg(RegStartMarker, s);
    write_reg(RegEndMarker, e);
  endtask

  // Payload without the end marker; now and then the start marker on purpose.
  function automatic byte_t payload_byte();
    byte_t b;
    if ($urandom_range(0, 11) == 0 && start_mark != end_mark) return start_mark;
    do b = byte_t'($urandom); while (b == end_mark);
    return b;
  endfunction

  // Line noise, weighted toward the two markers.
  function automatic byte_t noise_byte();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return start_mark;
    if (r == 1) return end_mark;
    return byte_t'($urandom);
  endfunction

  // Default markers: drops outside a frame, empty frame, byte extremes and
  // a start marker carried as payload.
  task automatic test_default_markers();
    send_rx_byte(8'h00);              // dropped
    send_rx_byte(EndMarkerReset);     // end marker outside a frame: dropped
    send_rx_byte(StartMarkerReset);
    send_rx_byte(EndMarkerReset);     // empty frame
    send_rx_byte(StartMarkerReset);
    send_rx_byte(8'hFF);
    send_rx_byte(StartMarkerReset);   // stored as payload
    send_rx_byte(8'h00);
    send_rx_byte(EndMarkerReset);
  endtask

  // Markers at the ends of the byte range, both ways round.
  task automatic test_extreme_markers();
    set_markers(8'h00, 8'hFF);
    send_rx_byte(8'h00);
    send_rx_byte(8'h80);
    send_rx_byte(8'h7F);
    send_rx_byte(8'hFF);
    set_markers(8'hFF, 8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h00);
  endtask

  // Same value for both markers: it opens outside a frame, closes inside.
  task automatic test_equal_markers();
    set_markers(8'h7E, 8'h7E);
    send_rx_byte(8'h7E);
    send_rx_byte(8'h7E);
    send_rx_byte(8'h7E);
    send_rx_byte(8'h11);
    send_rx_byte(8'h7E);
  endtask

  // Writes past the last register must leave the markers alone.
  task automatic test_spare_registers();
    set_markers(StartMarkerReset, EndMarkerReset);
    write_reg(RegSpareLo, 8'hFF);
    write_reg(RegSpareHi, 8'h00);
    send_rx_byte(StartMarkerReset);
    send_rx_byte(8'hA5);
    send_rx_byte(EndMarkerReset);
  endtask

  // Mostly well-formed frames with random payload, some long enough to
  // overflow; the rest noise and broken sequences. Close any open frame at
  // the end so that nothing is owed across a register write.
  task automatic run_random_phase(int target);
    int len;
    used_items = 0;
    while (used_items < target) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 2)) send_rx_byte(byte_t'($urandom));
        send_rx_byte(start_mark);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
        repeat (len) send_rx_byte(payload_byte());
        send_rx_byte(end_mark);
      end else begin
        repeat ($urandom_range(1, 6)) send_rx_byte(noise_byte());
      end
    end
    quiet = 1'b0;
    if (frame_open) send_rx_byte(end_mark);
  endtask

  task automatic test_random_frames();
    byte_t s;
    byte_t e;
    set_markers(StartMarkerReset, EndMarkerReset);
    run_random_phase(48);
    s = byte_t'($urandom);
    do e = byte_t'($urandom); while (e == s);
    set_markers(s, e);
    run_random_phase(48);
    s = byte_t'($urandom);
    set_markers(s, s);
    run_random_phase(48);
    set_markers(8'h00, 8'hFF);
    run_random_phase(48);
  endtask

  // Result side: stall tx_o at random, held free in quiet stretches.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (n > 0) begin
        tx_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      tx_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  // Check every accepted result against the oldest owed one.
  initial begin
    beat_t got;
    beat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && tx_if.valid === 1'b1 && tx_if.ready === 1'b1) begin
        got = '{tx_if.frame_byte, tx_if.is_last, tx_if.frame_empty};
        if (pending_beats.size() == 0) begin
          flag_mismatch(1'b0, '0, got);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) flag_mismatch(1'b1, want, got);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    tx_if.ready      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_markers();
    test_extreme_markers();
    test_equal_markers();
    test_spare_registers();
    test_random_frames();

    drain_frames();
    repeat (12) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mfbr_pkg.sv
src/mfbr_ifs.sv
src/mfbr_ram.sv
src/marker_framed_byte_receiver_core.sv
bench/tb.sv
